>>> src/bcl_pkg.sv
// shared constants, types and state codes of the bond cluster labeler
`timescale 1ns / 1ps
`default_nettype none

package bcl_pkg;

    localparam int MAX_PARTICLES       = 1024;
    localparam int INDEX_W             = 10;
    localparam int COUNT_W             = $clog2(MAX_PARTICLES + 1);
    localparam int LABEL_W             = 10;
    localparam int LABEL_LIMIT         = 512;
    localparam int NUM_PARTICLES_RESET = 1024;
    localparam int CFG_W               = 11;

    typedef logic [LABEL_W-1:0] label_t;

    localparam label_t NO_LABEL = '1;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BOND  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_RD_A,
        ST_RD_B,
        ST_EVAL,
        ST_WR_B,
        ST_MERGE,
        ST_DONE
    } state_t;

    typedef struct packed {
        label_t             label;
        logic [LABEL_W-1:0] count;
    } result_t;

endpackage

`default_nettype wire

>>> src/bcl_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module bcl_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> src/bcl_seq.sv
// sequencer that reads, updates and sweeps the label table
`timescale 1ns / 1ps
`default_nettype none

module bcl_seq (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [bcl_pkg::COUNT_W-1:0] n_eff,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [1:0]                  operation,
    input  wire logic [bcl_pkg::INDEX_W-1:0] first_index,
    input  wire logic [bcl_pkg::INDEX_W-1:0] second_index,
    input  wire logic                        bonded,
    output logic                             res_valid,
    input  wire logic                        res_take,
    output bcl_pkg::result_t                 result
);

    bcl_pkg::state_t state_reg, state_next;

    logic [bcl_pkg::COUNT_W-1:0] k_reg, k_next;
    logic [1:0]                  op_reg;
    logic [bcl_pkg::INDEX_W-1:0] first_reg, second_reg;
    logic                        bonded_reg;
    bcl_pkg::label_t             la_reg, la_next;
    bcl_pkg::label_t             lb_reg, lb_next;
    bcl_pkg::label_t             res_label_reg, res_label_next;
    logic [bcl_pkg::LABEL_W-1:0] next_label_reg, next_label_next;
    logic [bcl_pkg::LABEL_W-1:0] live_reg, live_next;
    logic                        pend_reg, pend_next;
    logic [bcl_pkg::INDEX_W-1:0] pend_addr_reg, pend_addr_next;

    logic                        mem_we;
    logic [bcl_pkg::INDEX_W-1:0] mem_waddr;
    bcl_pkg::label_t             mem_wdata;
    logic [bcl_pkg::INDEX_W-1:0] mem_raddr;
    bcl_pkg::label_t             mem_rdata;

    logic accept;
    logic apply;
    logic first_in_use;
    logic la_none, lb_none;
    logic labels_left;
    logic clear_end, merge_end, init_end;

    bcl_ram #(
        .WIDTH (bcl_pkg::LABEL_W),
        .DEPTH (bcl_pkg::MAX_PARTICLES)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign in_ready     = (state_reg == bcl_pkg::ST_IDLE);
    assign accept       = in_valid && in_ready;
    assign first_in_use = {1'b0, first_reg} < n_eff;
    assign apply        = (op_reg == bcl_pkg::OP_BOND) && bonded_reg
                          && (first_reg < second_reg) && ({1'b0, second_reg} < n_eff);
    assign la_none      = (la_reg == bcl_pkg::NO_LABEL);
    assign lb_none      = (mem_rdata == bcl_pkg::NO_LABEL);
    assign labels_left  = next_label_reg < bcl_pkg::LABEL_W'(bcl_pkg::LABEL_LIMIT);
    assign clear_end    = !(k_reg < n_eff);
    assign merge_end    = clear_end && !pend_reg;
    assign init_end     = (k_reg == bcl_pkg::COUNT_W'(bcl_pkg::MAX_PARTICLES));

    assign res_valid    = (state_reg == bcl_pkg::ST_DONE);
    assign result.label = res_label_reg;
    assign result.count = live_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bcl_pkg::ST_INIT:
            begin
                if (init_end)
                begin
                    state_next = bcl_pkg::ST_IDLE;
                end
            end
            bcl_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (operation == bcl_pkg::OP_START) ? bcl_pkg::ST_CLEAR
                                                                  : bcl_pkg::ST_RD_A;
                end
            end
            bcl_pkg::ST_CLEAR:
            begin
                if (clear_end)
                begin
                    state_next = bcl_pkg::ST_DONE;
                end
            end
            bcl_pkg::ST_RD_A:
            begin
                state_next = bcl_pkg::ST_RD_B;
            end
            bcl_pkg::ST_RD_B:
            begin
                state_next = bcl_pkg::ST_EVAL;
            end
            bcl_pkg::ST_EVAL:
            begin
                state_next = bcl_pkg::ST_DONE;
                if (apply && la_none && lb_none && labels_left)
                begin
                    state_next = bcl_pkg::ST_WR_B;
                end
                else if (apply && !la_none && !lb_none && (la_reg != mem_rdata))
                begin
                    state_next = bcl_pkg::ST_MERGE;
                end
            end
            bcl_pkg::ST_WR_B:
            begin
                state_next = bcl_pkg::ST_DONE;
            end
            bcl_pkg::ST_MERGE:
            begin
                if (merge_end)
                begin
                    state_next = bcl_pkg::ST_DONE;
                end
            end
            bcl_pkg::ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = bcl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bcl_pkg::ST_IDLE;
            end
        endcase
    end

    // memory accesses and datapath
    always_comb
    begin
        k_next          = k_reg;
        la_next         = la_reg;
        lb_next         = lb_reg;
        res_label_next  = res_label_reg;
        next_label_next = next_label_reg;
        live_next       = live_reg;
        pend_next       = 1'b0;
        pend_addr_next  = pend_addr_reg;
        mem_we          = 1'b0;
        mem_waddr       = k_reg[bcl_pkg::INDEX_W-1:0];
        mem_wdata       = bcl_pkg::NO_LABEL;
        mem_raddr       = first_reg;
        unique case (state_reg)
            bcl_pkg::ST_INIT:
            begin
                if (!init_end)
                begin
                    mem_we = 1'b1;
                    k_next = k_reg + 1'b1;
                end
                else
                begin
                    k_next = '0;
                end
            end
            bcl_pkg::ST_IDLE:
            begin
                k_next = '0;
            end
            bcl_pkg::ST_CLEAR:
            begin
                if (!clear_end)
                begin
                    mem_we = 1'b1;
                    k_next = k_reg + 1'b1;
                end
                else
                begin
                    next_label_next = '0;
                    live_next       = '0;
                    res_label_next  = bcl_pkg::NO_LABEL;
                end
            end
            bcl_pkg::ST_RD_A:
            begin
                mem_raddr = first_reg;
            end
            bcl_pkg::ST_RD_B:
            begin
                mem_raddr = second_reg;
                la_next   = mem_rdata;
            end
            bcl_pkg::ST_EVAL:
            begin
                lb_next        = mem_rdata;
                res_label_next = first_in_use ? la_reg : bcl_pkg::NO_LABEL;
                if (apply)
                begin
                    if (la_none && lb_none)
                    begin
                        if (labels_left)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = first_reg;
                            mem_wdata = next_label_reg;
                        end
                    end
                    else if (la_none)
                    begin
                        mem_we         = 1'b1;
                        mem_waddr      = first_reg;
                        mem_wdata      = mem_rdata;
                        res_label_next = mem_rdata;
                    end
                    else if (lb_none)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = second_reg;
                        mem_wdata = la_reg;
                    end
                end
            end
            bcl_pkg::ST_WR_B:
            begin
                mem_we          = 1'b1;
                mem_waddr       = second_reg;
                mem_wdata       = next_label_reg;
                res_label_next  = next_label_reg;
                next_label_next = next_label_reg + 1'b1;
                live_next       = live_reg + 1'b1;
            end
            bcl_pkg::ST_MERGE:
            begin
                mem_raddr = k_reg[bcl_pkg::INDEX_W-1:0];
                if (!clear_end)
                begin
                    pend_next      = 1'b1;
                    pend_addr_next = k_reg[bcl_pkg::INDEX_W-1:0];
                    k_next         = k_reg + 1'b1;
                end
                // write back one entry behind the read
                if (pend_reg && (mem_rdata == lb_reg))
                begin
                    mem_we    = 1'b1;
                    mem_waddr = pend_addr_reg;
                    mem_wdata = la_reg;
                end
                if (merge_end && (live_reg != '0))
                begin
                    live_next = live_reg - 1'b1;
                end
            end
            bcl_pkg::ST_DONE:
            begin
                k_next = '0;
            end
            default:
            begin
                k_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bcl_pkg::ST_INIT;
            k_reg          <= '0;
            next_label_reg <= '0;
            live_reg       <= '0;
            pend_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            k_reg          <= k_next;
            next_label_reg <= next_label_next;
            live_reg       <= live_next;
            pend_reg       <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= operation;
            first_reg  <= first_index;
            second_reg <= second_index;
            bonded_reg <= bonded;
        end
        la_reg        <= la_next;
        lb_reg        <= lb_next;
        res_label_reg <= res_label_next;
        pend_addr_reg <= pend_addr_next;
    end

endmodule

`default_nettype wire

>>> src/bond_cluster_labeler.sv
// top level of the bond cluster labeler: config register, sequencer, output register
//
//  channel  | signals                                         | direction
//  ---------+-------------------------------------------------+----------
//  cfg      | cfg_valid cfg_ready cfg_data[10:0]              | in
//  in       | in_valid in_ready operation first_index         | in
//           | second_index bonded                             |
//  out      | out_valid out_ready label clusters              | out
//
//  query, ignored bond or single write: rd_a, rd_b, eval, done, output register
//  new cluster adds wr_b after eval; start and merge sweep the entries in use
//  through the one write and one read port of the label ram (states clear, merge)
//  after reset a clearing pass over all 1024 entries runs before any transaction
//  a result waits in the output register while the next transaction is taken
`timescale 1ns / 1ps
`default_nettype none

module bond_cluster_labeler (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [bcl_pkg::CFG_W-1:0]         cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [1:0]                        operation,
    input  wire logic [bcl_pkg::INDEX_W-1:0]       first_index,
    input  wire logic [bcl_pkg::INDEX_W-1:0]       second_index,
    input  wire logic                              bonded,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [bcl_pkg::LABEL_W-1:0]     label,
    output logic        [bcl_pkg::LABEL_W-1:0]     clusters
);

    logic [bcl_pkg::CFG_W-1:0]   num_particles_reg;
    logic [bcl_pkg::COUNT_W-1:0] n_eff;
    logic                        out_valid_reg;
    bcl_pkg::result_t            out_reg;
    bcl_pkg::result_t            result;
    logic                        res_valid;
    logic                        res_take;

    assign cfg_ready = 1'b1;
    assign n_eff = (num_particles_reg > bcl_pkg::CFG_W'(bcl_pkg::MAX_PARTICLES))
                   ? bcl_pkg::COUNT_W'(bcl_pkg::MAX_PARTICLES)
                   : bcl_pkg::COUNT_W'(num_particles_reg);

    assign res_take  = res_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign label     = $signed(out_reg.label);
    assign clusters  = out_reg.count;

    bcl_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .n_eff        (n_eff),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .first_index  (first_index),
        .second_index (second_index),
        .bonded       (bonded),
        .res_valid    (res_valid),
        .res_take     (res_take),
        .result       (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_particles_reg <= bcl_pkg::CFG_W'(bcl_pkg::NUM_PARTICLES_RESET);
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                num_particles_reg <= cfg_data;
            end
            if (res_take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= result;
        end
    end

endmodule

`default_nettype wire
